[sv/sgclu_pkg.sv]
// Shared types and constants for the graph-cut label update block.
package sgclu_pkg;

    localparam int unsigned ModelW = 48;
    localparam int unsigned SumW   = 24;
    localparam int unsigned GradW  = 18;
    localparam int unsigned WeightW = 16;
    localparam int unsigned ScaleW = 32;
    localparam int unsigned AnchorW = 6;

    // node rows and data points; the port widths are sized for these
    localparam int unsigned NodeCount  = 16;
    localparam int unsigned PointCount = 64;

    localparam logic [ModelW-1:0] FracOne = 48'h0100_0000_0000;

    // register values after reset
    localparam logic [ScaleW-1:0]  StepScaleReset  = 32'd2251799814;
    localparam logic [AnchorW-1:0] AnchorZeroReset = 6'd1;
    localparam logic [AnchorW-1:0] AnchorOneReset  = 6'd2;

    // configuration register indexes
    localparam logic [1:0] CfgStepScale  = 2'd0;
    localparam logic [1:0] CfgAnchorZero = 2'd1;
    localparam logic [1:0] CfgAnchorOne  = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_GRAD  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CALC  = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    // Saturate a wide signed value to the model width.
    function automatic logic signed [ModelW-1:0] sat_model(input logic signed [81:0] v);
        logic signed [81:0] hi;
        logic signed [81:0] lo;
        hi = 82'sd140737488355327;
        lo = -82'sd140737488355328;
        if (v > hi) return hi[ModelW-1:0];
        if (v < lo) return lo[ModelW-1:0];
        return v[ModelW-1:0];
    endfunction

endpackage

[sv/sag_graph_cut_label_update.sv]
// Top level: one SAG step per edge over a two-class node labeling.
//
//  channel  direction  words
//  s_       in         one edge (point, two nodes, weight)
//  m_       out        one updated node row, last_row on final
//  cfg_     in         register index and write data
//
// An edge passes an idle state, forms the gradient sign from both endpoint
// rows, then walks each node row (read, multiply, saturate, project and
// write back, emit); a skipped anchor endpoint row leaves out the saturate
// and project steps and is not written back.
// After reset a clearing pass zeroes every slot of the stored gradient
// memory; no edge is accepted during it.
// A stalled result word holds the walk in place; configuration is taken
// only while idle.
module sag_graph_cut_label_update
    import sgclu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [5:0]   s_point_index,
    input  logic [3:0]   s_first_node,
    input  logic [3:0]   s_second_node,
    input  logic [15:0]  s_edge_weight,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [3:0]   m_node_id,
    output logic signed [47:0] m_class_zero_value,
    output logic signed [47:0] m_class_one_value,
    output logic         m_last_row,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned NodeW  = (NodeCount > 1) ? $clog2(NodeCount) : 1;
    localparam int unsigned PointW = (PointCount > 1) ? $clog2(PointCount) : 1;
    localparam int unsigned SlotCount = NodeCount * PointCount;
    localparam int unsigned SlotW  = PointW + NodeW;
    localparam int unsigned NodeCW = $clog2(NodeCount + 1);

    // configuration
    logic [ScaleW-1:0]  step_scale_reg;
    logic [AnchorW-1:0] anchor_zero_reg;
    logic [AnchorW-1:0] anchor_one_reg;

    state_t state_reg;

    assign cfg_ready = (state_reg == ST_IDLE) && !m_valid && !s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_scale_reg  <= StepScaleReset;
            anchor_zero_reg <= AnchorZeroReset;
            anchor_one_reg  <= AnchorOneReset;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CfgStepScale:  step_scale_reg  <= cfg_data;
                CfgAnchorZero: anchor_zero_reg <= cfg_data[AnchorW-1:0];
                CfgAnchorOne:  anchor_one_reg  <= cfg_data[AnchorW-1:0];
                default: ;
            endcase
        end
    end

    // memories: model rows, gradient sums, stored gradients
    logic [2*ModelW-1:0] row_mem [NodeCount];
    logic [2*SumW-1:0]   sum_mem [NodeCount];
    logic [2*GradW-1:0]  grad_mem [SlotCount];
    logic [NodeCount-1:0] row_written_reg;
    logic [NodeCount-1:0] sum_written_reg;

    logic [SlotW-1:0]  clr_reg;
    logic [PointW-1:0] pt_reg;
    logic [3:0]        n1_reg, n2_reg;
    logic signed [WeightW:0] w_reg;
    logic              a1_reg, a2_reg;
    logic [NodeW-1:0]  node_reg;
    logic [NodeCW-1:0] remain_reg;
    logic [1:0]        neg_reg;
    logic [1:0]        phase_reg;

    // read side
    logic [NodeW-1:0]    rd_node;
    logic [2*ModelW-1:0] row_q_reg;
    logic [2*SumW-1:0]   sum_q_reg;
    logic [2*GradW-1:0]  grad_q_reg;
    logic                row_ok_reg, sum_ok_reg;
    logic [2*ModelW-1:0] row_init;
    logic [2*ModelW-1:0] row_rd;
    logic [2*SumW-1:0]   sum_rd;
    logic [SlotW-1:0]    slot;

    // unwritten rows hold the one-hot pattern of the anchors at reset
    always_comb begin
        row_init = '0;
        if (32'(AnchorZeroReset) == 32'(rd_node)) row_init[ModelW-1:0] = FracOne;
        if (32'(AnchorOneReset) == 32'(rd_node)) row_init[2*ModelW-1:ModelW] = FracOne;
    end

    logic [2*ModelW-1:0] row_init_reg;
    assign row_rd = row_ok_reg ? row_q_reg : row_init_reg;
    assign sum_rd = sum_ok_reg ? sum_q_reg : '0;
    assign slot = {pt_reg, node_reg};

    logic        wr_en;
    logic [2*ModelW-1:0] wr_row;
    logic [2*SumW-1:0]   wr_sum;
    logic [2*GradW-1:0]  wr_grad;

    always_ff @(posedge aclk) begin
        row_q_reg    <= row_mem[rd_node];
        sum_q_reg    <= sum_mem[rd_node];
        grad_q_reg   <= grad_mem[slot];
        row_ok_reg   <= row_written_reg[rd_node];
        sum_ok_reg   <= sum_written_reg[rd_node];
        row_init_reg <= row_init;
        if (wr_en) begin
            row_mem[node_reg] <= wr_row;
            sum_mem[node_reg] <= wr_sum;
        end
        if (state_reg == ST_CLEAR) grad_mem[clr_reg] <= '0;
        else if (wr_en) grad_mem[slot] <= wr_grad;
    end

    // endpoint read for gradient sign: first n1 then n2 through rd_node
    always_comb begin
        rd_node = node_reg;
        if (state_reg == ST_GRAD) rd_node = (phase_reg == 2'd0) ? n1_reg[NodeW-1:0]
                                                                : n2_reg[NodeW-1:0];
    end

    logic signed [ModelW:0] m1_z_reg, m1_o_reg;
    logic signed [ModelW:0] m2_z, m2_o;

    // second endpoint row, zero when out of range
    always_comb begin
        m2_z = (32'(n2_reg) < NodeCount) ?
            (ModelW+1)'($signed(row_rd[ModelW-1:0])) : (ModelW+1)'(0);
        m2_o = (32'(n2_reg) < NodeCount) ?
            (ModelW+1)'($signed(row_rd[2*ModelW-1:ModelW])) : (ModelW+1)'(0);
    end

    // per-class update
    logic signed [GradW-1:0] g0, g1, p0, p1;
    logic signed [SumW+1:0]  t0, t1;
    logic signed [SumW+1:0]  s0n, s1n;
    logic is_n1, is_n2;

    always_comb begin
        is_n1 = (32'(node_reg) == 32'(n1_reg));
        is_n2 = (32'(node_reg) == 32'(n2_reg));
        g0 = '0;
        g1 = '0;
        if (is_n1) begin
            g0 = neg_reg[0] ? -GradW'(w_reg) : GradW'(w_reg);
            g1 = neg_reg[1] ? -GradW'(w_reg) : GradW'(w_reg);
        end else if (is_n2) begin
            g0 = neg_reg[0] ? GradW'(w_reg) : -GradW'(w_reg);
            g1 = neg_reg[1] ? GradW'(w_reg) : -GradW'(w_reg);
        end
        p0 = grad_q_reg[GradW-1:0];
        p1 = grad_q_reg[2*GradW-1:GradW];
        t0 = (SumW+2)'(g0) - (SumW+2)'(p0) + (SumW+2)'($signed(sum_rd[SumW-1:0]));
        t1 = (SumW+2)'(g1) - (SumW+2)'(p1) + (SumW+2)'($signed(sum_rd[2*SumW-1:SumW]));
        s0n = (SumW+2)'($signed(sum_rd[SumW-1:0])) - (SumW+2)'(p0) + (SumW+2)'(g0);
        s1n = (SumW+2)'($signed(sum_rd[2*SumW-1:SumW])) - (SumW+2)'(p1) + (SumW+2)'(g1);
    end

    function automatic logic signed [SumW-1:0] sat_sum(input logic signed [SumW+1:0] v);
        if (v > (SumW+2)'(8388607)) return SumW'(8388607);
        if (v < -(SumW+2)'(8388608)) return SumW'(-8388608);
        return v[SumW-1:0];
    endfunction

    // stage registers: products, then projection
    logic signed [58:0] prod0_reg, prod1_reg;
    logic signed [ModelW-1:0] v0_reg, v1_reg;
    logic signed [ModelW-1:0] r0_reg, r1_reg;
    logic [2*SumW-1:0]  sum_new_reg;
    logic [2*GradW-1:0] grad_new_reg;

    logic signed [ModelW-1:0] u0, u1;
    always_comb begin
        u0 = sat_model(82'($signed(row_rd[ModelW-1:0])) - 82'(prod0_reg >>> 8));
        u1 = sat_model(82'($signed(row_rd[2*ModelW-1:ModelW])) - 82'(prod1_reg >>> 8));
    end

    // simplex projection
    logic signed [ModelW+1:0] pa, pb, theta, d0, d1;
    logic signed [ModelW-1:0] q0, q1;
    always_comb begin
        if (v1_reg > v0_reg) begin
            pa = (ModelW+2)'(v1_reg);
            pb = (ModelW+2)'(v0_reg);
        end else begin
            pa = (ModelW+2)'(v0_reg);
            pb = (ModelW+2)'(v1_reg);
        end
        if (pa - pb < $signed((ModelW+2)'(FracOne)))
            theta = (pa + pb - $signed((ModelW+2)'(FracOne))) >>> 1;
        else theta = pa - $signed((ModelW+2)'(FracOne));
        d0 = (ModelW+2)'(v0_reg) - theta;
        d1 = (ModelW+2)'(v1_reg) - theta;
        q0 = sat_model(82'(d0 < 0 ? '0 : d0));
        q1 = sat_model(82'(d1 < 0 ? '0 : d1));
    end

    logic skip;
    assign skip = (is_n1 && a1_reg) || (is_n2 && a2_reg);

    assign wr_en = (state_reg == ST_CALC) && (phase_reg == 2'd2);
    assign wr_row = {q1, q0};
    assign wr_sum = sum_new_reg;
    assign wr_grad = grad_new_reg;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid;

    // last word unless a later node is still to be emitted
    logic last_node;
    logic skip_nx1, skip_nx2, last_word;
    logic emit_step;
    assign last_node = (32'(remain_reg) == 32'd1);
    assign skip_nx1 = ((32'(node_reg) + 1 == 32'(n1_reg)) && a1_reg) ||
                      ((32'(node_reg) + 1 == 32'(n2_reg)) && a2_reg);
    assign skip_nx2 = ((32'(node_reg) + 2 == 32'(n1_reg)) && a1_reg) ||
                      ((32'(node_reg) + 2 == 32'(n2_reg)) && a2_reg);
    assign last_word = last_node ||
                       ((32'(remain_reg) == 32'd2) && skip_nx1) ||
                       ((32'(remain_reg) == 32'd3) && skip_nx1 && skip_nx2);
    assign emit_step = (state_reg == ST_EMIT) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            m_valid         <= 1'b0;
            row_written_reg <= '0;
            sum_written_reg <= '0;
            phase_reg       <= '0;
        end else begin
            if (emit_step && !skip) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == SlotCount - 1) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        pt_reg <= PointW'(32'(s_point_index) % PointCount);
                        n1_reg <= s_first_node;
                        n2_reg <= s_second_node;
                        w_reg  <= (WeightW+1)'(s_edge_weight);
                        a1_reg <= (6'(s_first_node) == anchor_zero_reg) ||
                                  (6'(s_first_node) == anchor_one_reg);
                        a2_reg <= (6'(s_second_node) == anchor_zero_reg) ||
                                  (6'(s_second_node) == anchor_one_reg);
                        node_reg   <= '0;
                        remain_reg <= NodeCW'(NodeCount);
                        phase_reg  <= '0;
                        state_reg  <= ST_GRAD;
                    end
                end
                ST_GRAD: begin
                    // phase 0 issues n1, 1 issues n2 and captures n1, 2 captures n2
                    if (phase_reg == 2'd1) begin
                        m1_z_reg <= (32'(n1_reg) < NodeCount) ?
                            (ModelW+1)'($signed(row_rd[ModelW-1:0])) : (ModelW+1)'(0);
                        m1_o_reg <= (32'(n1_reg) < NodeCount) ?
                            (ModelW+1)'($signed(row_rd[2*ModelW-1:ModelW])) : (ModelW+1)'(0);
                    end
                    if (phase_reg == 2'd2) begin
                        neg_reg   <= {(m1_o_reg - m2_o) < 0, (m1_z_reg - m2_z) < 0};
                        phase_reg <= '0;
                        state_reg <= ST_READ;
                    end else begin
                        phase_reg <= phase_reg + 1'b1;
                    end
                end
                ST_READ: begin
                    // read data of node_reg lands next cycle
                    phase_reg <= '0;
                    state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    if (phase_reg == 2'd0) begin
                        prod0_reg   <= 59'(t0) * $signed({1'b0, step_scale_reg});
                        prod1_reg   <= 59'(t1) * $signed({1'b0, step_scale_reg});
                        sum_new_reg <= {sat_sum(s1n), sat_sum(s0n)};
                        grad_new_reg <= {g1, g0};
                        if (skip) begin
                            phase_reg <= '0;
                            state_reg <= ST_EMIT;
                        end else begin
                            phase_reg <= 2'd1;
                        end
                    end else if (phase_reg == 2'd1) begin
                        v0_reg <= u0;
                        v1_reg <= u1;
                        phase_reg <= 2'd2;
                    end else begin
                        r0_reg <= q0;
                        r1_reg <= q1;
                        row_written_reg[node_reg] <= 1'b1;
                        sum_written_reg[node_reg] <= 1'b1;
                        phase_reg <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_step) begin
                        if (!skip) begin
                            m_node_id          <= 4'(node_reg);
                            m_class_zero_value <= r0_reg;
                            m_class_one_value  <= r1_reg;
                            m_last_row         <= last_word;
                        end
                        remain_reg <= remain_reg - 1'b1;
                        node_reg   <= node_reg + 1'b1;
                        state_reg  <= last_node ? ST_IDLE : ST_READ;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // assertions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("edge taken during clear pass");
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !skip)
        else $error("anchor endpoint row written");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_class_zero_value))
        else $error("result changed while stalled");

endmodule
